// File: hw/rtl/scal_pkg.sv
`default_nettype none
package scal_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned ScalW = 256;
  localparam int unsigned InDataW = 520;
  localparam int unsigned OutDataW = 256;

  // group order n
  localparam logic [ScalW-1:0] OrderN =
    256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_BAAEDCE6_AF48A03B_BFD25E8C_D0364141;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_NEG = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  // item travelling down the double-and-add chain
  typedef struct packed {
    logic             mul;
    logic [ScalW-1:0] acc;
    logic [ScalW-1:0] y;
    logic [ScalW-1:0] x;
  } sc_item_t;

  // one subtraction of n when x >= n
  function automatic logic [ScalW-1:0] reduce_once(input logic [ScalW-1:0] x);
    logic [ScalW:0] t;
    t = {1'b0, x} - {1'b0, OrderN};
    return t[ScalW] ? x : t[ScalW-1:0];
  endfunction

  // (x + y) mod n for x, y below n
  function automatic logic [ScalW-1:0] add_mod(input logic [ScalW-1:0] x,
                                               input logic [ScalW-1:0] y);
    logic [ScalW:0]   s;
    logic [ScalW+1:0] t;
    s = {1'b0, x} + {1'b0, y};
    t = {1'b0, s} - {2'b0, OrderN};
    return t[ScalW+1] ? s[ScalW-1:0] : t[ScalW-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/scal_front.sv
`default_nettype none
module scal_front (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     in_vld,
  input  wire logic [1:0]               in_op,
  input  wire logic [scal_pkg::ScalW-1:0] in_a,
  input  wire logic [scal_pkg::ScalW-1:0] in_b,
  output logic                          out_vld,
  output scal_pkg::sc_item_t            out_item
);

  logic                        vld1_r;
  logic [1:0]                  op1_r;
  logic [scal_pkg::ScalW-1:0]  a1_r, b1_r;
  logic                        vld2_r;
  scal_pkg::sc_item_t          item2_r, item2_nxt;

  // operand reduction stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
    end
    if (en) begin
      op1_r <= in_op;
      a1_r  <= scal_pkg::reduce_once(in_a);
      b1_r  <= scal_pkg::reduce_once(in_b);
    end
  end

  // add, negate or set up the multiply
  always_comb begin
    item2_nxt.mul = 1'b0;
    item2_nxt.acc = '0;
    item2_nxt.y   = b1_r;
    item2_nxt.x   = a1_r;
    unique case (scal_pkg::op_t'(op1_r))
      scal_pkg::OP_ADD: item2_nxt.acc = scal_pkg::add_mod(a1_r, b1_r);
      scal_pkg::OP_MUL: item2_nxt.mul = 1'b1;
      scal_pkg::OP_NEG: item2_nxt.acc = (a1_r == '0) ? '0 : scal_pkg::OrderN - a1_r;
      default:          item2_nxt.acc = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
    if (en) begin
      item2_r <= item2_nxt;
    end
  end

  assign out_vld  = vld2_r;
  assign out_item = item2_r;

endmodule
`default_nettype wire

// File: hw/rtl/scal_step.sv
`default_nettype none
module scal_step (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_vld,
  input  wire scal_pkg::sc_item_t in_item,
  output logic                    out_vld,
  output scal_pkg::sc_item_t      out_item
);

  logic               vld_a_r, vld_b_r;
  scal_pkg::sc_item_t dbl_r, dbl_nxt, add_r, add_nxt;

  // doubling half
  always_comb begin
    dbl_nxt = in_item;
    if (in_item.mul) begin
      dbl_nxt.acc = scal_pkg::add_mod(in_item.acc, in_item.acc);
    end
  end

  // conditional add of y on the top bit of x
  always_comb begin
    add_nxt   = dbl_r;
    add_nxt.x = {dbl_r.x[scal_pkg::ScalW-2:0], 1'b0};
    if (dbl_r.mul && dbl_r.x[scal_pkg::ScalW-1]) begin
      add_nxt.acc = scal_pkg::add_mod(dbl_r.acc, dbl_r.y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
    end
    if (en) begin
      dbl_r <= dbl_nxt;
      add_r <= add_nxt;
    end
  end

  assign out_vld  = vld_b_r;
  assign out_item = add_r;

endmodule
`default_nettype wire

// File: hw/rtl/scalar_mod_order_alu.sv
// Pipelined arithmetic modulo the secp256k1 group order n: add, multiply and
// negate of 256-bit operands, operands at or above n reduced first, opcode 3
// gives zero. One request is taken every clock cycle whenever the result side
// is not stalled. Every opcode passes through the same pipeline, sized for the
// multiply, which runs as a chain of 256 double-and-add steps (two register
// stages each, one 256-bit modular add per stage) after two front stages and
// before the output register. A stall on out_tready freezes the whole pipe.
`default_nettype none
module scalar_mod_order_alu (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // op[1:0], a_w0..a_w3, b_w0..b_w3 from bit 2 up, zero pad to 520
  input  wire logic [scal_pkg::InDataW-1:0]   in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // r_w0, r_w1, r_w2, r_w3
  output logic [scal_pkg::OutDataW-1:0]       out_tdata
);

  localparam int unsigned Steps = scal_pkg::ScalW;

  logic                en;
  logic                vld_s   [Steps+1];
  scal_pkg::sc_item_t  item_s  [Steps+1];
  logic                out_vld_r;
  logic [scal_pkg::ScalW-1:0] out_data_r;

  // global advance: pipe moves when the output slot is free or drained
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  scal_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_tvalid),
    .in_op    (in_tdata[1:0]),
    .in_a     (in_tdata[2 +: scal_pkg::ScalW]),
    .in_b     (in_tdata[2+scal_pkg::ScalW +: scal_pkg::ScalW]),
    .out_vld  (vld_s[0]),
    .out_item (item_s[0])
  );

  // double-and-add chain, one bit of a per step
  for (genvar g = 0; g < Steps; g++) begin : g_step
    scal_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (vld_s[g]),
      .in_item  (item_s[g]),
      .out_vld  (vld_s[g+1]),
      .out_item (item_s[g+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_s[Steps];
    end
    if (en) begin
      out_data_r <= item_s[Steps].acc;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
